### design/vlit_pkg.sv
// Package for the video line index tracker.
// Shared types and constants; no dependencies.
package vlit_pkg;

  localparam int unsigned TICK_W     = 24;
  localparam int unsigned INDEX_W    = 25;
  localparam int unsigned IVL_W      = 28;
  localparam int unsigned FRAME_W    = 10;
  localparam int unsigned FRAC_SHIFT = 8;
  localparam int unsigned NUM_W      = TICK_W + FRAC_SHIFT + 1;  // 33-bit rounded numerator
  localparam int unsigned CNT_W      = $clog2(NUM_W + 1);
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = IVL_W;

  localparam logic [IVL_W-1:0]   IVL_RESET   = IVL_W'(2130620);
  localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(525);

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_LINE_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LINES   = 1'b1;

  // Event codes
  localparam logic ACT_RESTART    = 1'b0;
  localparam logic ACT_LINE_START = 1'b1;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [IVL_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

### design/vlit_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on vlit_pkg.
module vlit_div (
  input  logic              clk,
  input  logic              rst_n,
  input  vlit_pkg::div_req_t req,
  output vlit_pkg::div_rsp_t rsp
);

  logic [vlit_pkg::NUM_W-1:0] work_r, work_nxt;   // dividend in, quotient out
  logic [vlit_pkg::IVL_W-1:0] rem_r, rem_nxt;
  logic [vlit_pkg::IVL_W-1:0] den_r;
  logic [vlit_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       done_r, done_nxt;
  logic [vlit_pkg::IVL_W:0]   rem_sh;
  logic [vlit_pkg::IVL_W:0]   diff;
  logic                       ge;

  assign rem_sh = {rem_r, work_r[vlit_pkg::NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign diff   = rem_sh - {1'b0, den_r};

  always_comb begin
    work_nxt = work_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      work_nxt = req.num;
      rem_nxt  = '0;
      cnt_nxt  = vlit_pkg::CNT_W'(vlit_pkg::NUM_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? diff[vlit_pkg::IVL_W-1:0] : rem_sh[vlit_pkg::IVL_W-1:0];
      work_nxt = {work_r[vlit_pkg::NUM_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == vlit_pkg::CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    if (req.start) begin
      den_r <= req.den;
    end
  end

  assign rsp.busy = (cnt_r != '0);
  assign rsp.done = done_r;
  assign rsp.quot = work_r;

endmodule

### design/video_line_index_tracker_top.sv
// Top level of the video line index tracker: control sequencer, state and
// result register. Depends on vlit_pkg and vlit_div.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+----------------------------------
//  in_     | request   | in_valid / in_ready  | action, timestamp
//  out_    | result    | out_valid / out_ready| elapsed_ticks, half_line_index,
//          |           |                      | rebased
//  cfg_    | register  | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// Sequence: a line start goes from accept through a setup state (S_START), the
//   bit-serial divider, its registered done flag and the finish state (S_DONE);
//   a restart goes straight to the finish state. in_ready returns as the result
//   is registered, so a new request is taken only after the previous one has
//   finished. The 33-bit rounded numerator goes through the shared
//   one-bit-per-cycle divider.
// Reset: synchronous, active low; clears the sequencer, the base time and the
//   config registers to their defaults. No clearing pass.
// Stalls: the result sits in an output register; the finish cycle waits until
//   that register is free, so a new request may be taken while a result waits.
// The config port is always ready; writes are expected only while idle.
module video_line_index_tracker_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic [vlit_pkg::TICK_W-1:0]         in_timestamp,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [vlit_pkg::TICK_W-1:0]         out_elapsed_ticks,
  output logic [vlit_pkg::INDEX_W-1:0]        out_half_line_index,
  output logic                                out_rebased,
  // register write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vlit_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vlit_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_DIV   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [vlit_pkg::IVL_W-1:0]   ivl_r;
  logic [vlit_pkg::FRAME_W-1:0] frame_r;

  // tracker state and per-request context
  logic [vlit_pkg::TICK_W-1:0]  base_r, base_nxt;
  logic [vlit_pkg::TICK_W-1:0]  ts_r;
  logic [vlit_pkg::TICK_W-1:0]  t_r;
  logic                         act_r;

  // result register
  logic                         out_valid_r, out_valid_nxt;
  logic [vlit_pkg::TICK_W-1:0]  out_t_r;
  logic [vlit_pkg::INDEX_W-1:0] out_idx_r;
  logic                         out_reb_r;

  logic                         in_acc;
  logic                         out_free;
  logic                         finish;

  vlit_pkg::div_req_t           div_req;
  vlit_pkg::div_rsp_t           div_rsp;

  // finish-cycle datapath: saturate, rebase test, new base
  logic [vlit_pkg::INDEX_W-1:0] idx_sat;
  logic [vlit_pkg::INDEX_W-1:0] limit;
  logic [vlit_pkg::INDEX_W-1:0] excess;
  logic                         do_rebase;
  logic [vlit_pkg::TICK_W-1:0]  t_in;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign finish    = (state_r == S_DONE) && out_free;

  // elapsed ticks on a down-counter: base minus now, mod 2^24
  assign t_in = base_r - in_timestamp;

  // rounded numerator t*256 + interval/2 at full width
  assign div_req.start = (state_r == S_START);
  assign div_req.num   = {1'b0, t_r, vlit_pkg::FRAC_SHIFT'(0)}
                       + {{(vlit_pkg::NUM_W - vlit_pkg::IVL_W + 1){1'b0}},
                          ivl_r[vlit_pkg::IVL_W-1:1]};
  assign div_req.den   = ivl_r;

  vlit_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // zero interval gives an all-ones quotient, which saturates here too
  assign idx_sat   = (|div_rsp.quot[vlit_pkg::NUM_W-1:vlit_pkg::INDEX_W])
                     ? {vlit_pkg::INDEX_W{1'b1}}
                     : div_rsp.quot[vlit_pkg::INDEX_W-1:0];
  assign limit     = {{(vlit_pkg::INDEX_W - vlit_pkg::FRAME_W - 1){1'b0}}, frame_r, 1'b0};
  assign do_rebase = (act_r == vlit_pkg::ACT_LINE_START) && (idx_sat >= limit);
  // excess half lines come straight off the timestamp as ticks
  assign excess    = idx_sat - limit;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_action == vlit_pkg::ACT_LINE_START) ? S_START : S_DONE;
        end
      end
      S_START: state_nxt = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    base_nxt = base_r;
    if (in_acc && (in_action == vlit_pkg::ACT_RESTART)) begin
      base_nxt = in_timestamp;
    end else if (finish && do_rebase) begin
      base_nxt = ts_r - excess[vlit_pkg::TICK_W-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      out_valid_r <= 1'b0;
      ivl_r       <= vlit_pkg::IVL_RESET;
      frame_r     <= vlit_pkg::FRAME_RESET;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          vlit_pkg::REG_LINE_INTERVAL: ivl_r   <= cfg_wdata;
          vlit_pkg::REG_FRAME_LINES:   frame_r <= cfg_wdata[vlit_pkg::FRAME_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ts_r  <= in_timestamp;
      t_r   <= t_in;
      act_r <= in_action;
    end
    if (finish) begin
      if (act_r == vlit_pkg::ACT_LINE_START) begin
        out_t_r   <= t_r;
        out_idx_r <= idx_sat;
        out_reb_r <= do_rebase;
      end else begin
        out_t_r   <= '0;
        out_idx_r <= '0;
        out_reb_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_elapsed_ticks   = out_t_r;
  assign out_half_line_index = out_idx_r;
  assign out_rebased         = out_reb_r;

`ifndef ASSERT_OFF
  // divider is never running while a new request can come in
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_rsp.busy)
    else $error("divider busy while idle");

  // a restart skips the divider
  a_restart_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_action == vlit_pkg::ACT_RESTART)) |=> (state_r == S_DONE))
    else $error("restart did not go straight to finish");

  // a quotient only lands while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider done outside divide state");
`endif

endmodule

### tb/sv/tb_video_line_index_tracker_top.sv
// Self-checking testbench for video_line_index_tracker_top: directed table, then random phases.
// Requests are checked against an in-bench predictor of the half-line index and rebase logic.
// Depends on vlit_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_video_line_index_tracker_top;

  typedef struct packed {
    logic [vlit_pkg::TICK_W-1:0]  elapsed;
    logic [vlit_pkg::INDEX_W-1:0] half_idx;
    logic                         rebased;
  } line_result_t;

  typedef enum logic {ROW_REQ, ROW_REG} row_kind_t;

  // One row of the directed table: a request (expected value optionally typed in) or a
  // register write.
  typedef struct {
    row_kind_t                       kind;
    logic                            act;
    logic [vlit_pkg::TICK_W-1:0]     ts;
    logic                            typed;
    line_result_t                    want;
    logic [vlit_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [vlit_pkg::CFG_DATA_W-1:0] wdata;
  } row_t;

  // One random phase: register setting, request count, and whether the sender idles.
  typedef struct {
    logic [vlit_pkg::IVL_W-1:0]   ivl;
    logic [vlit_pkg::FRAME_W-1:0] frames;
    int                           count;
    bit                           steady;
  } phase_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic                            in_action;
  logic [vlit_pkg::TICK_W-1:0]     in_timestamp;
  logic                            out_valid;
  logic                            out_ready;
  logic [vlit_pkg::TICK_W-1:0]     out_elapsed_ticks;
  logic [vlit_pkg::INDEX_W-1:0]    out_half_line_index;
  logic                            out_rebased;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [vlit_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [vlit_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // Predictor state: base time and a shadow of both registers.
  logic [vlit_pkg::TICK_W-1:0]  shadow_base;
  logic [vlit_pkg::IVL_W-1:0]   shadow_interval;
  logic [vlit_pkg::FRAME_W-1:0] shadow_frames;

  line_result_t pending_results[$];         // expected results, oldest first
  logic [vlit_pkg::TICK_W-1:0] cursor;      // running timestamp of the random line sequence

  int mismatches      = 0;
  int results_checked = 0;
  int requests_sent   = 0;
  int restarts_sent   = 0;
  int rebases_seen    = 0;
  int reg_writes      = 0;
  int settings_run    = 0;

  video_line_index_tracker_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_timestamp       (in_timestamp),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_elapsed_ticks  (out_elapsed_ticks),
    .out_half_line_index(out_half_line_index),
    .out_rebased        (out_rebased),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Predict one request and advance the base time. Restart loads the base and
  // gives all zeros; a line start rounds t*256/interval at full width,
  // saturates at the 25-bit limit (a zero interval saturates outright) and
  // rebases by subtracting the half-line excess from the timestamp.
  function automatic line_result_t track_line_event(logic act,
                                                    logic [vlit_pkg::TICK_W-1:0] ts);
    line_result_t                 res;
    longint unsigned              num;
    longint unsigned              quot;
    logic [vlit_pkg::INDEX_W-1:0] limit;
    logic [vlit_pkg::INDEX_W-1:0] excess;
    res = '0;
    if (act == vlit_pkg::ACT_RESTART) begin
      shadow_base = ts;
      return res;
    end
    res.elapsed = shadow_base - ts;
    if (shadow_interval == '0) begin
      res.half_idx = '1;
    end else begin
      num  = 64'(res.elapsed);
      num  = (num << vlit_pkg::FRAC_SHIFT) + 64'(shadow_interval >> 1);
      quot = num / 64'(shadow_interval);
      res.half_idx = ((quot >> vlit_pkg::INDEX_W) != 0) ? '1 : vlit_pkg::INDEX_W'(quot);
    end
    limit = vlit_pkg::INDEX_W'({shadow_frames, 1'b0});
    if (res.half_idx >= limit) begin
      excess      = res.half_idx - limit;
      shadow_base = ts - excess[vlit_pkg::TICK_W-1:0];
      res.rebased = 1'b1;
    end
    return res;
  endfunction

  // Mostly no gap, some short ones, a few long.
  function automatic int next_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Frame register word: junk in the unused upper bits.
  function automatic logic [vlit_pkg::CFG_DATA_W-1:0] frame_word(
      logic [vlit_pkg::FRAME_W-1:0] f);
    logic [31:0] junk;
    junk = $urandom;
    return {junk[vlit_pkg::CFG_DATA_W-vlit_pkg::FRAME_W-1:0], f};
  endfunction

  function automatic row_t req_row(logic act, logic [vlit_pkg::TICK_W-1:0] ts);
    row_t r;
    r = '{kind: ROW_REQ, act: act, ts: ts, typed: 1'b0, want: '0, reg_idx: '0, wdata: '0};
    return r;
  endfunction

  function automatic row_t checked_row(logic act, logic [vlit_pkg::TICK_W-1:0] ts,
                                       logic [vlit_pkg::TICK_W-1:0] e,
                                       logic [vlit_pkg::INDEX_W-1:0] h, logic rb);
    row_t r;
    r = req_row(act, ts);
    r.typed = 1'b1;
    r.want  = '{elapsed: e, half_idx: h, rebased: rb};
    return r;
  endfunction

  function automatic row_t reg_row(logic [vlit_pkg::CFG_IDX_W-1:0] idx,
                                   logic [vlit_pkg::CFG_DATA_W-1:0] data);
    row_t r;
    r = '{kind: ROW_REG, act: 1'b0, ts: '0, typed: 1'b0, want: '0, reg_idx: idx, wdata: data};
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatches < 10) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Offer one request; entered and left at a falling edge. A zero gap keeps
  // valid high and only swaps the payload.
  task automatic push_request(logic act, logic [vlit_pkg::TICK_W-1:0] ts, bit steady,
                              logic typed, line_result_t want);
    int           gap;
    line_result_t res;
    gap = next_gap(steady);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_action    = act;
    in_timestamp = ts;
    do @(posedge clk); while (!in_ready);
    // accepted: predict now, so the base time follows acceptance order
    res = track_line_event(act, ts);
    if (typed) res = want;
    pending_results.push_back(res);
    requests_sent++;
    if (act == vlit_pkg::ACT_RESTART) restarts_sent++;
    if (res.rebased) rebases_seen++;
    @(negedge clk);
  endtask

  // Sender pause: drop valid and wait for every outstanding result.
  task automatic drain_block();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [vlit_pkg::CFG_IDX_W-1:0] idx,
                           logic [vlit_pkg::CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == vlit_pkg::REG_LINE_INTERVAL) shadow_interval = data[vlit_pkg::IVL_W-1:0];
    else shadow_frames = data[vlit_pkg::FRAME_W-1:0];
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Next random request: mostly a line sequence walking the down-counter by
  // whole and fractional half-line periods, plus restarts and plain noise.
  task automatic draw_request(output logic act, output logic [vlit_pkg::TICK_W-1:0] ts);
    int              r;
    int unsigned     k;
    longint unsigned step;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      act = 1'($urandom_range(0, 1));
      ts  = vlit_pkg::TICK_W'($urandom);
    end else if (r < 14) begin
      act    = vlit_pkg::ACT_RESTART;
      ts     = vlit_pkg::TICK_W'($urandom);
      cursor = ts;
    end else begin
      act = vlit_pkg::ACT_LINE_START;
      if ($urandom_range(0, 3) == 0) k = $urandom_range(0, 2 * shadow_frames + 3);
      else k = $urandom_range(0, 40);
      if (shadow_interval == '0) begin
        step = $urandom_range(0, 65535);
      end else begin
        step = k;
        step = step * shadow_interval + $urandom_range(0, shadow_interval);
        step = step >> vlit_pkg::FRAC_SHIFT;
      end
      cursor = cursor - step[vlit_pkg::TICK_W-1:0];
      ts     = cursor;
    end
  endtask

  // Result side: compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    line_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with no request pending (elapsed %0h index %0h)",
                                out_elapsed_ticks, out_half_line_index));
      end else begin
        want = pending_results.pop_front();
        if (out_elapsed_ticks !== want.elapsed)
          flag_mismatch($sformatf("elapsed_ticks expected %0h, got %0h",
                                  want.elapsed, out_elapsed_ticks));
        if (out_half_line_index !== want.half_idx)
          flag_mismatch($sformatf("half_line_index expected %0h, got %0h",
                                  want.half_idx, out_half_line_index));
        if (out_rebased !== want.rebased)
          flag_mismatch($sformatf("rebased expected %0b, got %0b",
                                  want.rebased, out_rebased));
      end
    end
  end

  // Receiver: ready runs broken by random stalls. Twice it holds off for a
  // long stretch so the output register and the block behind it fill up and
  // the request side stalls.
  initial begin : receiver
    int run;
    int gap;
    int holds_done;
    holds_done = 0;
    out_ready  = 1'b0;
    @(negedge clk);
    forever begin
      if ((holds_done == 0 && results_checked >= 100) ||
          (holds_done == 1 && results_checked >= 450)) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        holds_done++;
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      out_ready = 1'b1;
      repeat (run) @(negedge clk);
      gap = next_gap(1'b0);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // Hard stop: well over the slowest correct run.
  initial begin : watchdog
    #12_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    row_t                        rows[$];
    phase_t                      plan[9];
    logic                        act;
    logic [vlit_pkg::TICK_W-1:0] ts;
    line_result_t                none;

    none            = '0;
    shadow_base     = '0;
    shadow_interval = vlit_pkg::IVL_RESET;
    shadow_frames   = vlit_pkg::FRAME_RESET;
    cursor          = '0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_action       = vlit_pkg::ACT_RESTART;
    in_timestamp    = '0;
    cfg_valid       = 1'b0;
    cfg_index       = vlit_pkg::REG_LINE_INTERVAL;
    cfg_wdata       = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table. Defaults after reset: interval 2130620, 525 lines, base 0.
    rows.push_back(checked_row(vlit_pkg::ACT_LINE_START, 24'h000000, 24'h0, 25'h0, 1'b0));
    rows.push_back(checked_row(vlit_pkg::ACT_RESTART,    24'hFFFFFF, 24'h0, 25'h0, 1'b0));
    rows.push_back(checked_row(vlit_pkg::ACT_LINE_START, 24'hFFFFFF, 24'h0, 25'h0, 1'b0));
    rows.push_back(req_row(vlit_pkg::ACT_LINE_START, 24'h000000));  // full-range elapsed
    rows.push_back(checked_row(vlit_pkg::ACT_RESTART,    24'h800000, 24'h0, 25'h0, 1'b0));
    rows.push_back(req_row(vlit_pkg::ACT_LINE_START, 24'h7FBEFB));  // about one line later
    rows.push_back(req_row(vlit_pkg::ACT_LINE_START, 24'h800001));  // wraps backward
    // widest interval: rounding sum needs the 33rd bit
    rows.push_back(reg_row(vlit_pkg::REG_LINE_INTERVAL, 28'hFFFFFFF));
    rows.push_back(checked_row(vlit_pkg::ACT_RESTART,    24'hFFFFFF, 24'h0, 25'h0, 1'b0));
    rows.push_back(req_row(vlit_pkg::ACT_LINE_START, 24'h000000));
    // zero interval saturates the index, which then always rebases
    rows.push_back(reg_row(vlit_pkg::REG_LINE_INTERVAL, 28'h0));
    rows.push_back(checked_row(vlit_pkg::ACT_RESTART,    24'h000064, 24'h0, 25'h0, 1'b0));
    rows.push_back(checked_row(vlit_pkg::ACT_LINE_START, 24'h000028, 24'h3C, 25'h1FFFFFF,
                               1'b1));
    // interval below its range: index overflows 25 bits and saturates
    rows.push_back(reg_row(vlit_pkg::REG_LINE_INTERVAL, 28'h1));
    rows.push_back(req_row(vlit_pkg::ACT_LINE_START, 24'h123456));
    // shortest legal interval with the longest frame
    rows.push_back(reg_row(vlit_pkg::REG_LINE_INTERVAL, 28'd128));
    rows.push_back(reg_row(vlit_pkg::REG_FRAME_LINES, frame_word(10'd1023)));
    rows.push_back(req_row(vlit_pkg::ACT_LINE_START, 24'h122E56));
    // zero frame length: every line start rebases, even at index zero
    rows.push_back(reg_row(vlit_pkg::REG_FRAME_LINES, frame_word(10'd0)));
    rows.push_back(checked_row(vlit_pkg::ACT_RESTART,    24'h000000, 24'h0, 25'h0, 1'b0));
    rows.push_back(req_row(vlit_pkg::ACT_LINE_START, 24'hFFFF00));
    rows.push_back(req_row(vlit_pkg::ACT_LINE_START, 24'hFFFD00));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        drain_block();
        write_reg(rows[i].reg_idx, rows[i].wdata);
      end else begin
        push_request(rows[i].act, rows[i].ts, 1'b0, rows[i].typed, rows[i].want);
      end
    end
    settings_run = 5;

    // Random phases: defaults, both extremes, zero and sub-range intervals,
    // zero frame length, short frames at full rate, and fully random settings.
    plan[0] = '{ivl: vlit_pkg::IVL_RESET, frames: vlit_pkg::FRAME_RESET, count: 120,
                steady: 1'b0};
    plan[1] = '{ivl: 28'd128,     frames: 10'd1,    count: 80, steady: 1'b0};
    plan[2] = '{ivl: 28'hFFFFFFF, frames: 10'd1023, count: 80, steady: 1'b0};
    plan[3] = '{ivl: 28'd0,       frames: vlit_pkg::FRAME_RESET, count: 40, steady: 1'b0};
    plan[4] = '{ivl: vlit_pkg::IVL_W'($urandom_range(1, 127)),
                frames: vlit_pkg::FRAME_W'($urandom), count: 40, steady: 1'b0};
    plan[5] = '{ivl: vlit_pkg::IVL_W'($urandom_range(128, 28'hFFFFFFF)), frames: 10'd0,
                count: 60, steady: 1'b0};
    plan[6] = '{ivl: vlit_pkg::IVL_W'($urandom_range(1_000_000, 4_000_000)),
                frames: vlit_pkg::FRAME_W'($urandom_range(1, 40)), count: 150,
                steady: 1'b1};
    plan[7] = '{ivl: vlit_pkg::IVL_W'($urandom), frames: vlit_pkg::FRAME_W'($urandom),
                count: 100, steady: 1'b0};
    plan[8] = '{ivl: vlit_pkg::IVL_RESET, frames: vlit_pkg::FRAME_RESET, count: 130,
                steady: 1'b0};

    foreach (plan[p]) begin
      drain_block();
      write_reg(vlit_pkg::REG_LINE_INTERVAL, vlit_pkg::CFG_DATA_W'(plan[p].ivl));
      write_reg(vlit_pkg::REG_FRAME_LINES, frame_word(plan[p].frames));
      settings_run++;
      // start each phase from a fresh base
      cursor = vlit_pkg::TICK_W'($urandom);
      push_request(vlit_pkg::ACT_RESTART, cursor, plan[p].steady, 1'b0, none);
      repeat (plan[p].count) begin
        draw_request(act, ts);
        push_request(act, ts, plan[p].steady, 1'b0, none);
      end
    end

    // all requests in: wait for the tail, then let the pipeline settle
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("Covered %0d requests (%0d restarts, %0d rebases) over %0d register settings",
             requests_sent, restarts_sent, rebases_seen, settings_run);
    $display("%0d register writes, %0d results checked, %0d mismatches",
             reg_writes, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
